// ===== rtl/fpap_pkg.sv =====
// ----------------------------------------------------------------------------
// fpap_pkg: shared types, codes and fp16 arithmetic for the average pool
// Pass kinds, register indexes, the queue entry type and the fp16 add,
// multiply, pack and clamp functions used by the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

package fpap_pkg;

   localparam int FPAP_MAX_CHANNELS = 1024;

   localparam logic [1:0] KIND_FIRST  = 2'd0;
   localparam logic [1:0] KIND_MIDDLE = 2'd1;
   localparam logic [1:0] KIND_LAST   = 2'd2;
   localparam logic [1:0] KIND_SKIP   = 2'd3;

   localparam logic [1:0] REG_CHANNEL_COUNT = 2'd0;
   localparam logic [1:0] REG_OUTPUT_MIN    = 2'd1;
   localparam logic [1:0] REG_OUTPUT_MAX    = 2'd2;

   localparam logic [15:0] FP16_QNAN = 16'h7E00;
   localparam logic [14:0] FP16_INF  = 15'h7C00;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] p;
      logic [15:0] s;
      logic [15:0] qr;
      logic [15:0] t8;
      logic [15:0] scale;
   } fpap_op_type;

   typedef struct packed {
      logic              sgn;
      logic              nan;
      logic              inf;
      logic [21:0]       pr;
      logic signed [7:0] k;
   } fpap_prod_type;

   function automatic int ch_width(input int n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

   function automatic logic is_nan(input logic [15:0] a);
      return (a[14:10] == 5'h1f) && (a[9:0] != 10'd0);
   endfunction

   function automatic logic is_inf(input logic [15:0] a);
      return (a[14:10] == 5'h1f) && (a[9:0] == 10'd0);
   endfunction

   function automatic logic [10:0] sig_of(input logic [15:0] a);
      return {a[14:10] != 5'd0, a[9:0]};
   endfunction

   function automatic logic [4:0] exp_of(input logic [15:0] a);
      return (a[14:10] == 5'd0) ? 5'd1 : a[14:10];
   endfunction

   function automatic logic [5:0] lead42(input logic [41:0] m);
      logic [5:0] l;
      l = 6'd0;
      for (int i = 0; i < 42; i++) begin
         if (m[i]) l = 6'(i);
      end
      return l;
   endfunction

   // shift right with round to nearest even
   function automatic logic [41:0] rne_shr(input logic [41:0] m, input logic [5:0] d);
      logic [41:0] kept;
      logic [41:0] rem;
      logic [41:0] half;
      if (d == 6'd0) return m;
      kept = m >> d;
      rem  = m & ((42'd1 << d) - 42'd1);
      half = 42'd1 << (d - 6'd1);
      if ((rem > half) || ((rem == half) && kept[0])) kept = kept + 42'd1;
      return kept;
   endfunction

   // value = m * 2^(k-24), rounded to fp16
   function automatic logic [15:0] fp16_pack(input logic sgn, input logic [41:0] m,
                                             input logic signed [7:0] k);
      logic [5:0]        l;
      logic signed [8:0] d;
      logic signed [8:0] nk;
      logic signed [8:0] lsb;
      logic [41:0]       kept;
      logic [19:0]       h;
      if (m == 42'd0) return {sgn, 15'd0};
      l  = lead42(m);
      nk = -{k[7], k};
      d  = $signed({3'b000, l}) - 9'sd10;
      if (d < nk) d = nk;
      if (d >= 9'sd0) kept = rne_shr(m, d[5:0]);
      else            kept = m << 6'(-d);
      lsb = d + {k[7], k};
      if (lsb > 9'sd30) return {sgn, FP16_INF};
      h = (20'(lsb[4:0]) << 10) + kept[19:0];
      if (h >= 20'h07C00) return {sgn, FP16_INF};
      return {sgn, h[14:0]};
   endfunction

   function automatic logic [15:0] fp16_add(input logic [15:0] a, input logic [15:0] b);
      logic [39:0] fa;
      logic [39:0] fb;
      logic [41:0] mag;
      logic        sgn;
      logic [5:0]  l;
      logic [5:0]  d;
      if (is_nan(a) || is_nan(b)) return FP16_QNAN;
      if (is_inf(a) && is_inf(b)) return (a[15] != b[15]) ? FP16_QNAN : a;
      if (is_inf(a)) return a;
      if (is_inf(b)) return b;
      fa = 40'(sig_of(a)) << (exp_of(a) - 5'd1);
      fb = 40'(sig_of(b)) << (exp_of(b) - 5'd1);
      if (a[15] == b[15]) begin
         mag = 42'(fa) + 42'(fb);
         sgn = a[15];
      end else if (fa >= fb) begin
         mag = 42'(fa - fb);
         sgn = a[15];
      end else begin
         mag = 42'(fb - fa);
         sgn = b[15];
      end
      if (mag == 42'd0) return {a[15] & b[15], 15'd0};
      // binary32 rounding first, then fp16
      l = lead42(mag);
      if (l >= 6'd24) begin
         d   = l - 6'd23;
         mag = rne_shr(mag, d) << d;
      end
      return fp16_pack(sgn, mag, 8'sd0);
   endfunction

   function automatic fpap_prod_type fp16_mul_pre(input logic [15:0] a, input logic [15:0] b);
      fpap_prod_type r;
      logic          az;
      logic          bz;
      az    = (a[14:0] == 15'd0);
      bz    = (b[14:0] == 15'd0);
      r.sgn = a[15] ^ b[15];
      r.nan = is_nan(a) || is_nan(b) || (is_inf(a) && bz) || (is_inf(b) && az);
      r.inf = is_inf(a) || is_inf(b);
      r.pr  = 22'(sig_of(a)) * 22'(sig_of(b));
      r.k   = $signed({3'b000, exp_of(a)}) + $signed({3'b000, exp_of(b)}) - 8'sd26;
      return r;
   endfunction

   function automatic logic [15:0] fp16_mul_post(input fpap_prod_type r);
      if (r.nan) return FP16_QNAN;
      if (r.inf) return {r.sgn, FP16_INF};
      return fp16_pack(r.sgn, 42'(r.pr), r.k);
   endfunction

   function automatic logic fp16_lt(input logic [15:0] a, input logic [15:0] b);
      logic [15:0] ka;
      logic [15:0] kb;
      if (is_nan(a) || is_nan(b)) return 1'b0;
      if ((a[14:0] == 15'd0) && (b[14:0] == 15'd0)) return 1'b0;
      ka = a[15] ? ~a : {1'b1, a[14:0]};
      kb = b[15] ? ~b : {1'b1, b[14:0]};
      return ka < kb;
   endfunction

   // a nan value falls to the lower bound, a nan upper bound passes quieted
   function automatic logic [15:0] fp16_clamp(input logic [15:0] v, input logic [15:0] lo,
                                              input logic [15:0] hi);
      logic [15:0] c;
      c = fp16_lt(lo, v) ? v : lo;
      if (fp16_lt(c, hi)) return c;
      return is_nan(hi) ? (hi | 16'h0200) : hi;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/fpap_if.sv =====
// ----------------------------------------------------------------------------
// fpap_if: request and response channels of the average pool
// Valid/ready channels carrying one pass of window taps and one result.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpap_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [15:0] tap_0;
   logic [15:0] tap_1;
   logic [15:0] tap_2;
   logic [15:0] tap_3;
   logic [15:0] tap_4;
   logic [15:0] tap_5;
   logic [15:0] tap_6;
   logic [15:0] tap_7;
   logic [15:0] tap_8;
   logic [15:0] scale;
   modport source(output valid, kind, tap_0, tap_1, tap_2, tap_3, tap_4, tap_5, tap_6,
                  tap_7, tap_8, scale, input ready);
   modport sink(input valid, kind, tap_0, tap_1, tap_2, tap_3, tap_4, tap_5, tap_6,
                tap_7, tap_8, scale, output ready);
endinterface

interface fpap_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] result_value;
   logic [9:0]  channel;
   modport source(output valid, result_value, channel, input ready);
   modport sink(input valid, result_value, channel, output ready);
endinterface

`default_nettype wire

// ===== rtl/fpap_ram.sv =====
// ----------------------------------------------------------------------------
// fpap_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fpap_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                                 clock,
   input  wire logic                                 wr_en,
   input  wire logic [fpap_pkg::ch_width(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                     wr_data,
   input  wire logic                                 rd_en,
   input  wire logic [fpap_pkg::ch_width(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                     rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data <= mem[rd_addr];
   end
endmodule

`default_nettype wire

// ===== rtl/fpap_queue.sv =====
// ----------------------------------------------------------------------------
// fpap_queue: short queue between front and back
// Small flop queue that lets each side stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module fpap_queue #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  empty,
   output logic      [WIDTH-1:0] head
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == (PW+1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = data_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      count_in = count_ff + (PW+1)'(do_push) - (PW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) data_ff[wr_ptr_ff] <= push_data;
   end
endmodule

`default_nettype wire

// ===== rtl/fpap_front.sv =====
// ----------------------------------------------------------------------------
// fpap_front: request intake and channel sequencing
// Accepts passes, drops unused kinds, tags each with its channel and runs
// the adds that do not depend on the stored partial sum.
// ----------------------------------------------------------------------------
`default_nettype none

module fpap_front #(
   parameter int MAX_CHANNELS = fpap_pkg::FPAP_MAX_CHANNELS
) (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   fpap_req_if.sink                                         req,
   input  wire logic [10:0]                                 channel_count,
   output logic                                             push_valid,
   output fpap_pkg::fpap_op_type                            push_op,
   output logic      [fpap_pkg::ch_width(MAX_CHANNELS)-1:0] push_ch,
   input  wire logic                                        queue_full
);
   import fpap_pkg::*;

   localparam int CW = ch_width(MAX_CHANNELS);

   logic          accept;
   logic          f2_adv;
   logic [16:0]   limit;
   logic [CW-1:0] ch_ff, ch_in;

   logic          f1_v_ff, f1_v_in;
   logic [1:0]    f1_kind_ff;
   logic [15:0]   f1_tap_ff [9];
   logic [15:0]   f1_scale_ff;
   logic [CW-1:0] f1_ch_ff;

   logic          f2_v_ff, f2_v_in;
   logic [1:0]    f2_kind_ff;
   logic [15:0]   f2_p_ff, f2_q_ff, f2_r_ff, f2_s_ff, f2_t8_ff, f2_scale_ff;
   logic [CW-1:0] f2_ch_ff;

   assign f2_adv    = !f2_v_ff || !queue_full;
   assign req.ready = !f1_v_ff || f2_adv;
   assign accept    = req.valid && req.ready;

   always_comb begin
      limit = (channel_count == 11'd0) ? 17'd1 : {6'd0, channel_count};
      if (limit > 17'(MAX_CHANNELS)) limit = 17'(MAX_CHANNELS);
      ch_in = ch_ff;
      if (accept && (req.kind != KIND_SKIP)) begin
         ch_in = ((17'(ch_ff) + 17'd1) >= limit) ? '0 : CW'(17'(ch_ff) + 17'd1);
      end
      f1_v_in = f1_v_ff;
      if (req.ready) f1_v_in = accept && (req.kind != KIND_SKIP);
      f2_v_in = f2_adv ? f1_v_ff : f2_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ch_ff   <= '0;
         f1_v_ff <= 1'b0;
         f2_v_ff <= 1'b0;
      end else begin
         ch_ff   <= ch_in;
         f1_v_ff <= f1_v_in;
         f2_v_ff <= f2_v_in;
      end
      if (req.ready) begin
         f1_kind_ff   <= req.kind;
         f1_tap_ff[0] <= req.tap_0;
         f1_tap_ff[1] <= req.tap_1;
         f1_tap_ff[2] <= req.tap_2;
         f1_tap_ff[3] <= req.tap_3;
         f1_tap_ff[4] <= req.tap_4;
         f1_tap_ff[5] <= req.tap_5;
         f1_tap_ff[6] <= req.tap_6;
         f1_tap_ff[7] <= req.tap_7;
         f1_tap_ff[8] <= req.tap_8;
         f1_scale_ff  <= req.scale;
         f1_ch_ff     <= ch_ff;
      end
      if (f2_adv) begin
         f2_kind_ff  <= f1_kind_ff;
         f2_p_ff     <= fp16_add(f1_tap_ff[0], f1_tap_ff[1]);
         f2_q_ff     <= fp16_add(f1_tap_ff[2], f1_tap_ff[3]);
         f2_r_ff     <= fp16_add(f1_tap_ff[4], f1_tap_ff[5]);
         f2_s_ff     <= fp16_add(f1_tap_ff[6], f1_tap_ff[7]);
         f2_t8_ff    <= f1_tap_ff[8];
         f2_scale_ff <= f1_scale_ff;
         f2_ch_ff    <= f1_ch_ff;
      end
   end

   assign push_valid    = f2_v_ff;
   assign push_ch       = f2_ch_ff;
   assign push_op.kind  = f2_kind_ff;
   assign push_op.p     = f2_p_ff;
   assign push_op.s     = f2_s_ff;
   assign push_op.qr    = fp16_add(f2_q_ff, f2_r_ff);
   assign push_op.t8    = f2_t8_ff;
   assign push_op.scale = f2_scale_ff;
endmodule

`default_nettype wire

// ===== rtl/fpap_back.sv =====
// ----------------------------------------------------------------------------
// fpap_back: partial sum update, scaling and clamping
// Reads the channel's partial sum, finishes the add tree, writes it back,
// and for last passes scales, rounds, clamps and drives the result.
// ----------------------------------------------------------------------------
`default_nettype none

module fpap_back #(
   parameter int MAX_CHANNELS = fpap_pkg::FPAP_MAX_CHANNELS
) (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire logic                                        head_empty,
   input  wire fpap_pkg::fpap_op_type                       head_op,
   input  wire logic [fpap_pkg::ch_width(MAX_CHANNELS)-1:0] head_ch,
   output logic                                             pop,
   input  wire logic [15:0]                                 output_min,
   input  wire logic [15:0]                                 output_max,
   fpap_rsp_if.source                                       rsp
);
   import fpap_pkg::*;

   localparam int CW = ch_width(MAX_CHANNELS);

   logic          en, hazard, issue;
   logic [15:0]   acc, sum;

   logic          b1_v_ff;
   fpap_op_type   b1_op_ff;
   logic [CW-1:0] b1_ch_ff;

   logic          b2_v_ff;
   logic [1:0]    b2_kind_ff;
   logic [15:0]   b2_x_ff, b2_s_ff, b2_qr_ff, b2_scale_ff;
   logic [CW-1:0] b2_ch_ff;

   logic          b3_v_ff;
   logic [1:0]    b3_kind_ff;
   logic [15:0]   b3_y_ff, b3_qr_ff, b3_scale_ff;
   logic [CW-1:0] b3_ch_ff;

   logic          b4_v_ff;
   logic [15:0]   b4_sum_ff, b4_scale_ff;
   logic [CW-1:0] b4_ch_ff;

   logic          b5_v_ff;
   fpap_prod_type b5_prod_ff;
   logic [CW-1:0] b5_ch_ff;

   logic          b6_v_ff;
   logic [15:0]   b6_val_ff;
   logic [CW-1:0] b6_ch_ff;

   logic          rsp_v_ff;
   logic [15:0]   rsp_val_ff;
   logic [9:0]    rsp_ch_ff;

   assign en = !rsp_v_ff || rsp.ready;

   // a pass that needs the stored sum waits while that channel is in flight
   assign hazard = (head_op.kind != KIND_FIRST) &&
                   ((b1_v_ff && (b1_ch_ff == head_ch)) ||
                    (b2_v_ff && (b2_ch_ff == head_ch)) ||
                    (b3_v_ff && (b3_ch_ff == head_ch)));
   assign issue  = en && !head_empty && !hazard;
   assign pop    = issue;

   assign sum = fp16_add(b3_qr_ff, b3_y_ff);

   fpap_ram #(.WIDTH(16), .DEPTH(MAX_CHANNELS)) u_sums (
      .clock   (clock),
      .wr_en   (en && b3_v_ff),
      .wr_addr (b3_ch_ff),
      .wr_data (sum),
      .rd_en   (issue),
      .rd_addr (head_ch),
      .rd_data (acc)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_v_ff  <= 1'b0;
         b2_v_ff  <= 1'b0;
         b3_v_ff  <= 1'b0;
         b4_v_ff  <= 1'b0;
         b5_v_ff  <= 1'b0;
         b6_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else if (en) begin
         b1_v_ff  <= issue;
         b2_v_ff  <= b1_v_ff;
         b3_v_ff  <= b2_v_ff;
         b4_v_ff  <= b3_v_ff && (b3_kind_ff == KIND_LAST);
         b5_v_ff  <= b4_v_ff;
         b6_v_ff  <= b5_v_ff;
         rsp_v_ff <= b6_v_ff;
      end
      if (en) begin
         b1_op_ff    <= head_op;
         b1_ch_ff    <= head_ch;

         b2_kind_ff  <= b1_op_ff.kind;
         b2_x_ff     <= fp16_add(b1_op_ff.p,
                                 (b1_op_ff.kind == KIND_FIRST) ? b1_op_ff.t8 : acc);
         b2_s_ff     <= b1_op_ff.s;
         b2_qr_ff    <= b1_op_ff.qr;
         b2_scale_ff <= b1_op_ff.scale;
         b2_ch_ff    <= b1_ch_ff;

         b3_kind_ff  <= b2_kind_ff;
         b3_y_ff     <= fp16_add(b2_x_ff, b2_s_ff);
         b3_qr_ff    <= b2_qr_ff;
         b3_scale_ff <= b2_scale_ff;
         b3_ch_ff    <= b2_ch_ff;

         b4_sum_ff   <= sum;
         b4_scale_ff <= b3_scale_ff;
         b4_ch_ff    <= b3_ch_ff;

         b5_prod_ff  <= fp16_mul_pre(b4_sum_ff, b4_scale_ff);
         b5_ch_ff    <= b4_ch_ff;

         b6_val_ff   <= fp16_mul_post(b5_prod_ff);
         b6_ch_ff    <= b5_ch_ff;

         rsp_val_ff  <= fp16_clamp(b6_val_ff, output_min, output_max);
         rsp_ch_ff   <= 10'(b6_ch_ff);
      end
   end

   assign rsp.valid        = rsp_v_ff;
   assign rsp.result_value = rsp_val_ff;
   assign rsp.channel      = rsp_ch_ff;
endmodule

`default_nettype wire

// ===== rtl/fp16_pixel_average_pool.sv =====
// ----------------------------------------------------------------------------
// fp16_pixel_average_pool: fp16 average pooling accumulator
// Sums window taps per channel over several passes and emits the scaled,
// clamped average on the last pass of each channel.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one pass of one channel (first: nine taps, middle or last:
//   eight taps added to the stored partial sum); channels follow in order
//   0 .. channel_count-1. Kind 3 transactions are taken and dropped.
//   rsp carries one result per last pass with its channel index.
//   Registers: channel_count at 0x0, output_min at 0x4, output_max at 0x8;
//   write them only while no transaction is in flight.
// Timing:
//   a last pass runs through the front stages f1 and f2, the queue, the
//   back stages b1 to b6 and the rsp register. One transaction per cycle
//   is sustained while channel_count is 4 or more and rsp does not stall;
//   below that a middle or last pass waits until the previous pass of its
//   channel has left the read-add-write loop around the partial sum memory.
// Reset:
//   clears the channel counter, the queue and all valid flags and loads the
//   register defaults; the partial sums are not cleared (a first pass of a
//   channel writes it). A stalled rsp holds its result; the four-entry queue
//   keeps req flowing until it fills.
// ----------------------------------------------------------------------------
`default_nettype none

module fp16_pixel_average_pool #(
   parameter int MAX_CHANNELS = fpap_pkg::FPAP_MAX_CHANNELS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   fpap_req_if.sink         req,
   fpap_rsp_if.source       rsp,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready
);
   import fpap_pkg::*;

   localparam int CW = ch_width(MAX_CHANNELS);
   localparam int QW = $bits(fpap_op_type) + CW;

   logic [10:0]   count_ff;
   logic [15:0]   min_ff, max_ff;
   logic          wr;

   logic          push_valid, q_full, q_empty, pop;
   fpap_op_type   push_op, head_op;
   logic [CW-1:0] push_ch, head_ch;
   logic [QW-1:0] head;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 11'd1;
         min_ff   <= 16'hFC00;
         max_ff   <= 16'h7C00;
      end else if (wr) begin
         unique case (paddr[3:2])
            REG_CHANNEL_COUNT: count_ff <= pwdata[10:0];
            REG_OUTPUT_MIN:    min_ff   <= pwdata[15:0];
            REG_OUTPUT_MAX:    max_ff   <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_CHANNEL_COUNT: prdata = {21'd0, count_ff};
         REG_OUTPUT_MIN:    prdata = {16'd0, min_ff};
         REG_OUTPUT_MAX:    prdata = {16'd0, max_ff};
         default:           prdata = 32'd0;
      endcase
   end

   fpap_front #(.MAX_CHANNELS(MAX_CHANNELS)) u_front (
      .clock         (clock),
      .reset         (reset),
      .req           (req),
      .channel_count (count_ff),
      .push_valid    (push_valid),
      .push_op       (push_op),
      .push_ch       (push_ch),
      .queue_full    (q_full)
   );

   fpap_queue #(.WIDTH(QW), .DEPTH(4)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data ({push_ch, push_op}),
      .full      (q_full),
      .pop       (pop),
      .empty     (q_empty),
      .head      (head)
   );

   assign head_ch = head[QW-1 -: CW];
   assign head_op = fpap_op_type'(head[$bits(fpap_op_type)-1:0]);

   fpap_back #(.MAX_CHANNELS(MAX_CHANNELS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_empty (q_empty),
      .head_op    (head_op),
      .head_ch    (head_ch),
      .pop        (pop),
      .output_min (min_ff),
      .output_max (max_ff),
      .rsp        (rsp)
   );
endmodule

`default_nettype wire

// ===== tb/fp16_pixel_average_pool_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fp16_pixel_average_pool_test: self-checking testbench of the fp16 average pool
// Streams first, middle and last passes over several channel counts and clamp
// bounds, predicts each scaled, clamped average with a bit-exact fp16 model of
// the add tree and compares every response transaction in order.
// ----------------------------------------------------------------------------
module fp16_pixel_average_pool_test;
   import fpap_pkg::*;

   typedef struct {
      logic [1:0]  kind;
      logic [15:0] taps [9];
      logic [15:0] scale;
   } pass_item_type;

   typedef struct {
      logic [15:0] value;
      logic [9:0]  channel;
   } pool_result_type;

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [3:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic csr_pready;

   fpap_req_if req_ch ();
   fpap_rsp_if rsp_ch ();

   fp16_pixel_average_pool DUT (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source),
      .psel(csr_psel), .penable(csr_penable), .pwrite(csr_pwrite), .paddr(csr_paddr),
      .pwdata(csr_pwdata), .prdata(csr_prdata), .pready(csr_pready)
   );

   // stimulus side
   pass_item_type   pending_passes[$];
   int              gen_ctr;
   int              gen_limit;
   bit              gen_written [1024];
   bit              calm;
   bit              src_hold;
   int              hold_asked;

   // prediction side
   logic [10:0]     cfg_count;
   logic [15:0]     cfg_min;
   logic [15:0]     cfg_max;
   logic [15:0]     channel_sums [1024];
   int              pred_ctr;
   pool_result_type expected_averages[$];

   bit              req_taken;
   int              errors;
   int              passes_taken;
   int              averages_checked;
   int              idle_cycles;
   int              hold_seen;
   int              hold_left;

   logic [15:0] special_taps [10] = '{16'h0000, 16'h8000, 16'h7C00, 16'hFC00, 16'h7E00,
                                     16'h0001, 16'h7BFF, 16'hFBFF, 16'h0400, 16'h3C00};

   // ---------------- fp16 arithmetic, exact in wide integers ----------------

   function automatic logic nan16(input logic [15:0] a);
      return a[14:10] == 5'h1F && a[9:0] != 0;
   endfunction

   function automatic logic inf16(input logic [15:0] a);
      return a[14:10] == 5'h1F && a[9:0] == 0;
   endfunction

   function automatic int top_bit(input logic [95:0] m);
      int msb;
      msb = 0;
      for (int i = 0; i < 96; i++) if (m[i]) msb = i;
      return msb;
   endfunction

   function automatic logic [95:0] round_even_shift(input logic [95:0] m, input int d);
      logic [95:0] kept;
      logic [95:0] rem;
      logic [95:0] half;
      kept = m >> d;
      rem  = m & ((96'd1 << d) - 96'd1);
      half = 96'd1 << (d - 1);
      if (rem > half || (rem == half && kept[0])) kept = kept + 96'd1;
      return kept;
   endfunction

   // magnitude m counts units of 2^-48
   function automatic logic [15:0] round_to_half(input logic sgn, input logic [95:0] m);
      int msb;
      logic [95:0] kept;
      if (m == 0) return {sgn, 15'd0};
      msb = top_bit(m);
      if (msb - 48 < -25) return {sgn, 15'd0};
      if (msb - 48 >= -14) begin
         kept = round_even_shift(m, msb - 10) + (96'(msb - 48 + 14) << 10);
         if (kept >= 96'h7C00) return {sgn, 15'h7C00};
         return {sgn, kept[14:0]};
      end
      kept = round_even_shift(m, 24);
      return {sgn, kept[14:0]};
   endfunction

   function automatic logic [10:0] significand(input logic [15:0] a);
      return {a[14:10] != 0, a[9:0]};
   endfunction

   function automatic int exp_field(input logic [15:0] a);
      return (a[14:10] == 0) ? 1 : int'(a[14:10]);
   endfunction

   // single precision add, then narrowed to fp16
   function automatic logic [15:0] half_sum(input logic [15:0] a, input logic [15:0] b);
      logic [95:0] ma;
      logic [95:0] mb;
      logic [95:0] m;
      logic        sgn;
      int          msb;
      if (nan16(a) || nan16(b)) return 16'h7E00;
      if (inf16(a) && inf16(b)) return (a[15] != b[15]) ? 16'h7E00 : a;
      if (inf16(a)) return a;
      if (inf16(b)) return b;
      ma = 96'(significand(a)) << (exp_field(a) - 1 + 24);
      mb = 96'(significand(b)) << (exp_field(b) - 1 + 24);
      if (a[15] == b[15]) begin
         m = ma + mb;
         sgn = a[15];
      end else if (ma >= mb) begin
         m = ma - mb;
         sgn = a[15];
      end else begin
         m = mb - ma;
         sgn = b[15];
      end
      if (m == 0) return {a[15] & b[15], 15'd0};
      msb = top_bit(m);
      if (msb > 23) m = round_even_shift(m, msb - 23) << (msb - 23);
      return round_to_half(sgn, m);
   endfunction

   // the single precision product of two fp16 values is exact
   function automatic logic [15:0] half_product(input logic [15:0] a, input logic [15:0] b);
      logic sgn;
      sgn = a[15] ^ b[15];
      if (nan16(a) || nan16(b) || (inf16(a) && b[14:0] == 0) || (inf16(b) && a[14:0] == 0))
         return 16'h7E00;
      if (inf16(a) || inf16(b)) return {sgn, 15'h7C00};
      return round_to_half(sgn, (96'(significand(a)) * 96'(significand(b)))
                                << (exp_field(a) + exp_field(b) - 2));
   endfunction

   function automatic logic half_less(input logic [15:0] a, input logic [15:0] b);
      logic [15:0] ka;
      logic [15:0] kb;
      if (nan16(a) || nan16(b)) return 1'b0;
      if (a[14:0] == 0 && b[14:0] == 0) return 1'b0;
      ka = a[15] ? ~a : (a | 16'h8000);
      kb = b[15] ? ~b : (b | 16'h8000);
      return ka < kb;
   endfunction

   function automatic int effective_limit(input logic [10:0] cnt);
      if (cnt == 0) return 1;
      if (cnt > 1024) return 1024;
      return int'(cnt);
   endfunction

   // ---------------- stimulus helpers ----------------

   function automatic logic [15:0] rand_tap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return 16'($urandom);
      if (r < 21) return special_taps[$urandom_range(0, 9)];
      return {1'($urandom), 5'($urandom_range(10, 18)), 10'($urandom)};
   endfunction

   function automatic pass_item_type rand_pass(input logic [1:0] kind);
      pass_item_type it;
      it.kind = kind;
      foreach (it.taps[i]) it.taps[i] = rand_tap();
      if ($urandom_range(0, 9) == 0) it.scale = 16'($urandom);
      else it.scale = {1'($urandom_range(0, 5) == 0), 5'($urandom_range(8, 15)), 10'($urandom)};
      return it;
   endfunction

   function automatic pass_item_type fixed_pass(input logic [1:0] kind, input logic [15:0] t,
                                                input logic [15:0] t8, input logic [15:0] sc);
      pass_item_type it;
      it.kind = kind;
      foreach (it.taps[i]) it.taps[i] = t;
      it.taps[8] = t8;
      it.scale = sc;
      return it;
   endfunction

   // a channel never holding a sum gets a first pass instead
   task automatic queue_pass(input pass_item_type it);
      if (it.kind != KIND_SKIP) begin
         if (it.kind != KIND_FIRST && !gen_written[gen_ctr]) it.kind = KIND_FIRST;
         gen_written[gen_ctr] = 1'b1;
         gen_ctr++;
         if (gen_ctr >= gen_limit) gen_ctr = 0;
      end
      pending_passes.push_back(it);
   endtask

   task automatic queue_pixels(input int total);
      int n;
      int passes;
      logic [1:0] kind;
      n = 0;
      while (n < total) begin
         if ($urandom_range(0, 99) < 85) begin
            passes = $urandom_range(1, 4);
            for (int p = 0; p < passes; p++) begin
               kind = (p == 0) ? KIND_FIRST : (p == passes - 1) ? KIND_LAST : KIND_MIDDLE;
               for (int c = 0; c < gen_limit; c++) begin
                  queue_pass(rand_pass(kind));
                  n++;
                  if ($urandom_range(0, 99) < 2) queue_pass(rand_pass(KIND_SKIP));
               end
            end
         end else begin
            queue_pass(rand_pass(2'($urandom_range(0, 3))));
            n++;
         end
      end
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_passes.size() != 0 || req_ch.valid || expected_averages.size() != 0);
      repeat (16) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= 4'(idx) << 2;
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_CHANNEL_COUNT: begin
            cfg_count = data[10:0];
            gen_limit = effective_limit(data[10:0]);
         end
         REG_OUTPUT_MIN: cfg_min = data[15:0];
         REG_OUTPUT_MAX: cfg_max = data[15:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [10:0] cnt, input logic [15:0] lo,
                             input logic [15:0] hi);
      csr_write(REG_CHANNEL_COUNT, {$urandom} & 32'hFFFF_F800 | 32'(cnt));
      csr_write(REG_OUTPUT_MIN, {16'($urandom), lo});
      csr_write(REG_OUTPUT_MAX, {16'($urandom), hi});
   endtask

   // ---------------- clock and main sequence ----------------

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      pass_item_type it;
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      calm = 1'b0;
      src_hold = 1'b0;
      hold_asked = 0;
      gen_ctr = 0;
      gen_limit = 1;
      cfg_count = 11'd1;
      cfg_min = 16'hFC00;
      cfg_max = 16'h7C00;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed passes at the reset configuration, one channel
      queue_pass(fixed_pass(KIND_FIRST, 16'h0000, 16'h0000, 16'h0000));
      queue_pass(fixed_pass(KIND_LAST, 16'h0000, 16'h0000, 16'h3C00));
      queue_pass(fixed_pass(KIND_FIRST, 16'h7BFF, 16'h7BFF, 16'h0000));
      queue_pass(fixed_pass(KIND_LAST, 16'h0000, 16'h0000, 16'h0000));
      queue_pass(fixed_pass(KIND_FIRST, 16'h0001, 16'h0001, 16'h0000));
      queue_pass(fixed_pass(KIND_LAST, 16'h0001, 16'h0001, 16'h7BFF));
      it = fixed_pass(KIND_FIRST, 16'h3C00, 16'h3C00, 16'h0000);
      it.taps[0] = 16'h7C00;
      it.taps[1] = 16'hFC00;
      queue_pass(it);
      queue_pass(fixed_pass(KIND_MIDDLE, 16'h3C00, 16'h0000, 16'h0000));
      queue_pass(fixed_pass(KIND_LAST, 16'h3C00, 16'h0000, 16'h3C00));
      queue_pass(fixed_pass(KIND_FIRST, 16'h8000, 16'h8000, 16'h0000));
      queue_pass(fixed_pass(KIND_SKIP, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      queue_pass(fixed_pass(KIND_LAST, 16'h8000, 16'h8000, 16'h8000));
      queue_pass(fixed_pass(KIND_FIRST, 16'h3C00, 16'h3C00, 16'h0000));
      queue_pass(fixed_pass(KIND_MIDDLE, 16'h3C00, 16'h0000, 16'h0000));
      queue_pass(fixed_pass(KIND_LAST, 16'hBC00, 16'h0000, 16'h2C72));
      queue_pass(fixed_pass(KIND_FIRST, 16'hFFFF, 16'hFFFF, 16'h0000));
      queue_pass(fixed_pass(KIND_LAST, 16'h0000, 16'h0000, 16'hFFFF));
      queue_pass(fixed_pass(KIND_FIRST, 16'h7C00, 16'h7C00, 16'h0000));
      queue_pass(fixed_pass(KIND_LAST, 16'h7C00, 16'h7C00, 16'hFC00));
      queue_pass(fixed_pass(KIND_FIRST, 16'h0400, 16'h83FF, 16'h0000));
      queue_pass(fixed_pass(KIND_LAST, 16'h0200, 16'h0000, 16'h7BFF));
      wait_drained();

      // no idling, plus a long response stall so the request side backs up
      set_config(11'd3, 16'h0000, 16'h3C00);
      calm = 1'b1;
      queue_pixels(200);
      hold_asked++;
      wait_drained();
      calm = 1'b0;

      set_config(11'd2, 16'hBC00, 16'h7E01);
      queue_pixels(150);
      wait_drained();

      set_config(11'd0, 16'h7E00, 16'h7C00);
      queue_pixels(80);
      wait_drained();

      // count above the channel limit: a first pass over every channel, then wrap
      set_config(11'd2047, 16'hFC00, 16'h7C00);
      for (int c = 0; c < 1024; c++) queue_pass(rand_pass(KIND_FIRST));
      for (int c = 0; c < 32; c++) queue_pass(rand_pass(KIND_LAST));
      wait_drained();

      set_config(11'd1024, 16'h3C00, 16'h3800);
      for (int i = 0; i < 40; i++) queue_pass(rand_pass(2'($urandom_range(0, 3))));
      wait_drained();

      // counter now sits beyond the new count
      set_config(11'd5, 16'h8001, 16'h0001);
      queue_pixels(120);
      wait_drained();

      set_config(11'd16, 16'hFBFF, 16'h7BFF);
      queue_pixels(150);
      hold_asked++;
      wait_drained();

      set_config(11'd1, 16'hFC00, 16'h7C00);
      queue_pixels(60);
      wait_drained();

      $display("covered %0d passes and %0d checked averages over counts 0..2047",
               passes_taken, averages_checked);
      $display("clamp bounds included infinities, NaN bounds and an inverted range");
      if (errors == 0) begin
         $display("fp16_pixel_average_pool_test: clean");
      end else begin
         $display("fp16_pixel_average_pool_test: errors");
      end
      $finish;
   end

   // ---------------- request driver ----------------

   always @(negedge clock) begin
      pass_item_type it;
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.kind <= '0;
         req_ch.tap_0 <= '0;
         req_ch.tap_1 <= '0;
         req_ch.tap_2 <= '0;
         req_ch.tap_3 <= '0;
         req_ch.tap_4 <= '0;
         req_ch.tap_5 <= '0;
         req_ch.tap_6 <= '0;
         req_ch.tap_7 <= '0;
         req_ch.tap_8 <= '0;
         req_ch.scale <= '0;
      end else if (!req_ch.valid || req_taken) begin
         if (pending_passes.size() != 0 && !src_hold && (calm || $urandom_range(0, 99) >= 12)) begin
            it = pending_passes.pop_front();
            req_ch.kind <= it.kind;
            req_ch.tap_0 <= it.taps[0];
            req_ch.tap_1 <= it.taps[1];
            req_ch.tap_2 <= it.taps[2];
            req_ch.tap_3 <= it.taps[3];
            req_ch.tap_4 <= it.taps[4];
            req_ch.tap_5 <= it.taps[5];
            req_ch.tap_6 <= it.taps[6];
            req_ch.tap_7 <= it.taps[7];
            req_ch.tap_8 <= it.taps[8];
            req_ch.scale <= it.scale;
            req_ch.valid <= 1'b1;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // ---------------- response ready ----------------

   initial begin
      hold_seen = 0;
      hold_left = 0;
      rsp_ch.ready = 1'b0;
   end

   always @(negedge clock) begin
      if (hold_seen != hold_asked) begin
         hold_seen = hold_asked;
         hold_left = 300;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= calm || $urandom_range(0, 99) >= 12;
      end
   end

   // ---------------- monitor, predictor and checker ----------------

   initial begin
      req_taken = 1'b0;
      errors = 0;
      passes_taken = 0;
      averages_checked = 0;
      idle_cycles = 0;
      pred_ctr = 0;
   end

   always @(posedge clock) begin
      logic [15:0] t [9];
      logic [15:0] p;
      logic [15:0] q;
      logic [15:0] r;
      logic [15:0] s;
      logic [15:0] qr;
      logic [15:0] sum;
      logic [15:0] v;
      logic [15:0] c;
      pool_result_type want;
      req_taken = 1'b0;
      if (!reset) begin
         idle_cycles++;
         if (req_ch.valid && req_ch.ready) begin
            req_taken = 1'b1;
            idle_cycles = 0;
            passes_taken++;
            if (req_ch.kind != KIND_SKIP) begin
               t = '{req_ch.tap_0, req_ch.tap_1, req_ch.tap_2, req_ch.tap_3, req_ch.tap_4,
                     req_ch.tap_5, req_ch.tap_6, req_ch.tap_7, req_ch.tap_8};
               p = half_sum(t[0], t[1]);
               q = half_sum(t[2], t[3]);
               r = half_sum(t[4], t[5]);
               s = half_sum(t[6], t[7]);
               p = half_sum(p, (req_ch.kind == KIND_FIRST) ? t[8] : channel_sums[pred_ctr]);
               qr = half_sum(q, r);
               p = half_sum(p, s);
               sum = half_sum(qr, p);
               channel_sums[pred_ctr] = sum;
               if (req_ch.kind == KIND_LAST) begin
                  // NaN product falls to the lower bound, NaN upper bound passes quieted
                  v = half_product(sum, req_ch.scale);
                  c = half_less(cfg_min, v) ? v : cfg_min;
                  if (!half_less(c, cfg_max)) c = nan16(cfg_max) ? (cfg_max | 16'h0200) : cfg_max;
                  want.value = c;
                  want.channel = 10'(pred_ctr);
                  expected_averages.push_back(want);
               end
               pred_ctr++;
               if (pred_ctr >= effective_limit(cfg_count)) pred_ctr = 0;
            end
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            idle_cycles = 0;
            if (expected_averages.size() == 0) begin
               $error("unexpected response transaction: result_value %h channel %0d",
                      rsp_ch.result_value, rsp_ch.channel);
               errors++;
            end else begin
               want = expected_averages.pop_front();
               averages_checked++;
               if (rsp_ch.result_value !== want.value) begin
                  $error("result_value: expected %h actual %h", want.value, rsp_ch.result_value);
                  errors++;
               end
               if (rsp_ch.channel !== want.channel) begin
                  $error("channel: expected %0d actual %0d", want.channel, rsp_ch.channel);
                  errors++;
               end
            end
         end
         if (idle_cycles > 5000) begin
            $display("timeout: no transaction for %0d cycles", idle_cycles);
            $display("fp16_pixel_average_pool_test: errors");
            $finish;
         end
      end
   end

endmodule

// ===== fp16_pixel_average_pool.f =====
rtl/fpap_pkg.sv
rtl/fpap_if.sv
rtl/fpap_ram.sv
rtl/fpap_queue.sv
rtl/fpap_front.sv
rtl/fpap_back.sv
rtl/fp16_pixel_average_pool.sv
tb/fp16_pixel_average_pool_test.sv
